// File: rtl/trsc_pkg.sv
// ----------------------------------------------------------------------------
// trsc_pkg
// Shared constants and types for the two-register stack processor step block.
// ----------------------------------------------------------------------------
package trsc_pkg;

    localparam int ADDR_BITS = 16;
    localparam int MEM_WORDS = 1 << ADDR_BITS;
    localparam int WORD_W    = 32;
    localparam int CFG_W     = 17;
    localparam int ACTION_W  = 2;
    localparam int IN_ADDR_W = 16;
    localparam int STATUS_W  = 2;

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [WORD_W-1:0]    t_word;

    typedef enum logic [STATUS_W-1:0] {
        RS_RUNNING  = 2'd0,
        RS_HALTED   = 2'd1,
        RS_PAST_END = 2'd2
    } t_status;

endpackage

// File: rtl/two_register_stack_cpu_step.sv
// ----------------------------------------------------------------------------
// two_register_stack_cpu_step
// Two-register stack processor: program load, memory read and single-step
// execution against one synchronous word memory.
// ----------------------------------------------------------------------------
//  channel   | valid        | stall        | payload
//  ----------+--------------+--------------+----------------------------------
//  request   | i_in_valid   | o_in_stall   | i_action, i_address, i_data_word
//  result    | o_out_valid  | i_out_stall  | o_a_value .. o_read_data
//  config    | i_cfg_wr_en  | (none)       | i_cfg_wr_data
//
//  write and unused requests finish in the cycle they are taken; a read goes
//  through a data read, an execute through instruction fetch, then execute,
//  and ldl/ldnl add a second memory read on the single read port. a new read
//  or execute request is taken in the cycle the previous one finishes, so
//  back-to-back reads and executes other than ldl/ldnl run at one per cycle
//  while the result register is free. after reset a clearing pass zeroes the
//  memory, during which no request is taken; config writes are taken at any time.
//  a full result register with o_out_valid high and i_out_stall high holds
//  any request that would finish; fetches and data reads still proceed.
// ----------------------------------------------------------------------------
module two_register_stack_cpu_step (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [trsc_pkg::ACTION_W-1:0]   i_action,
    input  logic [trsc_pkg::IN_ADDR_W-1:0]  i_address,
    input  logic [trsc_pkg::WORD_W-1:0]     i_data_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [trsc_pkg::WORD_W-1:0] o_a_value,
    output logic signed [trsc_pkg::WORD_W-1:0] o_b_value,
    output logic signed [trsc_pkg::WORD_W-1:0] o_pc_value,
    output logic signed [trsc_pkg::WORD_W-1:0] o_sp_value,
    output logic [trsc_pkg::STATUS_W-1:0]   o_run_status,
    output logic [trsc_pkg::WORD_W-1:0]     o_read_data,
    input  logic                            i_cfg_wr_en,
    input  logic [trsc_pkg::CFG_W-1:0]      i_cfg_wr_data
);
    import trsc_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_INSTR = 5'b00100,
        ST_DATA  = 5'b01000,
        ST_RDATA = 5'b10000
    } t_state;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_EXEC  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [7:0] {
        OP_LDC  = 8'd0,  OP_ADC  = 8'd1,  OP_LDL  = 8'd2,  OP_STL  = 8'd3,
        OP_LDNL = 8'd4,  OP_STNL = 8'd5,  OP_ADD  = 8'd6,  OP_SUB  = 8'd7,
        OP_SHL  = 8'd8,  OP_SHR  = 8'd9,  OP_ADJ  = 8'd10, OP_A2SP = 8'd11,
        OP_SP2A = 8'd12, OP_CALL = 8'd13, OP_RET  = 8'd14, OP_BRZ  = 8'd15,
        OP_BRLZ = 8'd16, OP_BR   = 8'd17, OP_HALT = 8'd18
    } t_opcode;

    t_state             r_state, n_state;
    t_word              r_a, r_b, r_pc, r_sp;
    t_word              n_a, n_b, n_pc, n_sp;
    logic               r_halt, n_halt;
    logic [CFG_W-1:0]   r_prog_words;
    t_addr              r_clr_addr;

    t_word              r_mem [MEM_WORDS];
    t_word              r_mem_q;
    t_addr              r_ra, mem_ra;
    logic               r_fwd_hit;
    t_word              r_fwd_data;
    logic               mem_we;
    t_addr              mem_wa;
    t_word              mem_wd;
    t_word              mem_word;

    logic               r_out_valid;
    t_word              r_o_a, r_o_b, r_o_pc, r_o_sp, r_o_rd;
    logic [STATUS_W-1:0] r_o_status;

    logic               out_free;
    logic               imm_in;
    logic               accept;
    logic               fin;
    logic               load_go;
    t_addr              load_addr;
    logic               run_ok;
    logic [7:0]         opc;
    t_word              opd;
    t_word              pc_inc;
    logic               amt_ok;
    t_word              rd_out;
    t_status            n_status;

    function automatic logic below_len(input t_word pc, input logic [CFG_W-1:0] len);
        below_len = pc[WORD_W-1] || (pc < WORD_W'(len));
    endfunction

    // forwarding covers a read and a write of the same word at one edge
    assign mem_word = r_fwd_hit ? r_fwd_data : r_mem_q;
    assign out_free = !r_out_valid || !i_out_stall;
    assign imm_in   = (i_action == ACT_WRITE) || (i_action == ACT_NONE);

    assign opc    = mem_word[7:0];
    assign opd    = {{8{mem_word[WORD_W-1]}}, mem_word[WORD_W-1:8]};
    assign pc_inc = r_pc + WORD_W'(1);
    assign run_ok = !r_halt && below_len(r_pc, r_prog_words);
    assign amt_ok = (r_a[WORD_W-1:5] == '0);

    always_comb begin
        n_a       = r_a;
        n_b       = r_b;
        n_pc      = r_pc;
        n_sp      = r_sp;
        n_halt    = r_halt;
        fin       = 1'b0;
        load_go   = 1'b0;
        load_addr = r_ra;
        mem_we    = 1'b0;
        mem_wa    = t_addr'(i_address);
        mem_wd    = i_data_word;
        rd_out    = '0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr_addr;
                mem_wd = '0;
            end
            ST_IDLE: begin
                mem_we = i_in_valid && out_free && (i_action == ACT_WRITE);
            end
            ST_INSTR: begin
                if (!run_ok) begin
                    fin = out_free;
                end else if (opc == OP_LDL || opc == OP_LDNL) begin
                    load_go = 1'b1;
                    n_pc    = pc_inc;
                    if (opc == OP_LDL) begin
                        n_b       = r_a;
                        load_addr = t_addr'(r_sp + opd);
                    end else begin
                        load_addr = t_addr'(r_a + opd);
                    end
                end else if (out_free) begin
                    fin  = 1'b1;
                    n_pc = pc_inc;
                    unique case (opc)
                        OP_LDC: begin
                            n_b = r_a;
                            n_a = opd;
                        end
                        OP_ADC:  n_a = r_a + opd;
                        OP_STL: begin
                            mem_we = 1'b1;
                            mem_wa = t_addr'(r_sp + opd);
                            mem_wd = r_a;
                            n_a    = r_b;
                        end
                        OP_STNL: begin
                            mem_we = 1'b1;
                            mem_wa = t_addr'(r_a + opd);
                            mem_wd = r_b;
                        end
                        OP_ADD:  n_a = r_a + r_b;
                        OP_SUB:  n_a = r_b - r_a;
                        OP_SHL:  n_a = amt_ok ? (r_b << r_a[4:0]) : '0;
                        OP_SHR:  n_a = amt_ok ? t_word'($signed(r_b) >>> r_a[4:0])
                                              : {WORD_W{r_b[WORD_W-1]}};
                        OP_ADJ:  n_sp = r_sp + opd;
                        OP_A2SP: begin
                            n_sp = r_a;
                            n_a  = r_b;
                        end
                        OP_SP2A: begin
                            n_b = r_a;
                            n_a = r_sp;
                        end
                        OP_CALL: begin
                            n_b  = r_a;
                            n_a  = pc_inc;
                            n_pc = pc_inc + opd;
                        end
                        OP_RET: begin
                            n_pc = r_a;
                            n_a  = r_b;
                        end
                        OP_BRZ:  if (r_a == '0) n_pc = pc_inc + opd;
                        OP_BRLZ: if (r_a[WORD_W-1]) n_pc = pc_inc + opd;
                        OP_BR:   n_pc = pc_inc + opd;
                        OP_HALT: n_halt = 1'b1;
                        default: ;  // unknown opcodes only step the pc
                    endcase
                end
            end
            ST_DATA: begin
                if (out_free) begin
                    fin = 1'b1;
                    n_a = mem_word;
                end
            end
            ST_RDATA: begin
                fin    = out_free;
                rd_out = mem_word;
            end
            default: ;
        endcase
    end

    assign o_in_stall = !(((r_state == ST_IDLE) && (out_free || !imm_in)) || (fin && !imm_in));
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        if (n_halt) begin
            n_status = RS_HALTED;
        end else if (!below_len(n_pc, r_prog_words)) begin
            n_status = RS_PAST_END;
        end else begin
            n_status = RS_RUNNING;
        end
    end

    // read address and next state
    always_comb begin
        mem_ra  = r_ra;
        n_state = r_state;
        if (accept && i_action == ACT_EXEC) begin
            mem_ra = t_addr'(n_pc);
        end else if (accept && i_action == ACT_READ) begin
            mem_ra = t_addr'(i_address);
        end else if (load_go) begin
            mem_ra = load_addr;
        end

        priority if (r_state == ST_CLEAR) begin
            if (r_clr_addr == '1) n_state = ST_IDLE;
        end else if (load_go) begin
            n_state = ST_DATA;
        end else if (accept && i_action == ACT_EXEC) begin
            n_state = ST_INSTR;
        end else if (accept && i_action == ACT_READ) begin
            n_state = ST_RDATA;
        end else if (fin) begin
            n_state = ST_IDLE;
        end else begin
            n_state = r_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_mem_q <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        r_ra       <= mem_ra;
        r_fwd_hit  <= mem_we && (mem_wa == mem_ra);
        r_fwd_data <= mem_wd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_a          <= '0;
            r_b          <= '0;
            r_pc         <= '0;
            r_sp         <= '0;
            r_halt       <= 1'b0;
            r_prog_words <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + t_addr'(1);
            end
            r_a    <= n_a;
            r_b    <= n_b;
            r_pc   <= n_pc;
            r_sp   <= n_sp;
            r_halt <= n_halt;
            if (i_cfg_wr_en) begin
                r_prog_words <= i_cfg_wr_data;
            end
            if (fin || (accept && imm_in)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (fin || (accept && imm_in)) begin
            r_o_a      <= n_a;
            r_o_b      <= n_b;
            r_o_pc     <= n_pc;
            r_o_sp     <= n_sp;
            r_o_status <= n_status;
            r_o_rd     <= rd_out;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_a_value    = r_o_a;
    assign o_b_value    = r_o_b;
    assign o_pc_value   = r_o_pc;
    assign o_sp_value   = r_o_sp;
    assign o_run_status = r_o_status;
    assign o_read_data  = r_o_rd;

endmodule

// File: rtl/trsc_check.sv
// ----------------------------------------------------------------------------
// trsc_check
// Port-level checks for the two-register stack processor step block.
// ----------------------------------------------------------------------------
module trsc_check (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic signed [trsc_pkg::WORD_W-1:0]  o_a_value,
    input logic signed [trsc_pkg::WORD_W-1:0]  o_pc_value,
    input logic [trsc_pkg::STATUS_W-1:0]       o_run_status
);
    import trsc_pkg::*;

    logic taken_halted;

    assign taken_halted = o_out_valid && !i_out_stall && (o_run_status == RS_HALTED);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_pc_value) && $stable(o_a_value))
        else $error("result changed while stalled");

    // halt stays until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        taken_halted |=> !o_out_valid || (o_run_status == RS_HALTED))
        else $error("halt status dropped without reset");

    // nothing moves the pc once halted
    a_halt_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        taken_halted |=> !o_out_valid || (o_pc_value == $past(o_pc_value)))
        else $error("pc moved after halt");

    // register a stays too once halted
    a_halt_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        taken_halted |=> !o_out_valid || (o_a_value == $past(o_a_value)))
        else $error("register a changed after halt");

endmodule

bind two_register_stack_cpu_step trsc_check u_trsc_check (.*);

// File: tb/stack_cpu_tb_pkg.sv
// ----------------------------------------------------------------------------
// stack_cpu_tb_pkg
// Request and opcode codes for the stack processor bench, plus the state
// tracker that mirrors the processor and checks every returned state.
// ----------------------------------------------------------------------------
package stack_cpu_tb_pkg;

    import trsc_pkg::*;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_EXEC  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [7:0] {
        OP_LDC  = 8'd0,
        OP_ADC  = 8'd1,
        OP_LDL  = 8'd2,
        OP_STL  = 8'd3,
        OP_LDNL = 8'd4,
        OP_STNL = 8'd5,
        OP_ADD  = 8'd6,
        OP_SUB  = 8'd7,
        OP_SHL  = 8'd8,
        OP_SHR  = 8'd9,
        OP_ADJ  = 8'd10,
        OP_A2SP = 8'd11,
        OP_SP2A = 8'd12,
        OP_CALL = 8'd13,
        OP_RET  = 8'd14,
        OP_BRZ  = 8'd15,
        OP_BRLZ = 8'd16,
        OP_BR   = 8'd17,
        OP_HALT = 8'd18
    } t_opcode;

    localparam int OPCODE_COUNT = 19;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] pc;
        logic [WORD_W-1:0] sp;
        t_status           status;
        logic [WORD_W-1:0] rdata;
    } t_step_state;

    class cpu_state_tracker;
        bit [WORD_W-1:0] reg_a;
        bit [WORD_W-1:0] reg_b;
        bit [WORD_W-1:0] pc;
        bit [WORD_W-1:0] sp;
        bit              halted;
        bit [CFG_W-1:0]  prog_len;
        bit [WORD_W-1:0] mem [MEM_WORDS];
        t_step_state     expected_states[$];
        int              mismatches;

        function void set_length(logic [CFG_W-1:0] v);
            prog_len = v;
        endfunction

        function int pending();
            return expected_states.size();
        endfunction

        // a negative pc always counts as inside the program
        function bit pc_in_program();
            return pc[WORD_W-1] || (pc < prog_len);
        endfunction

        function void step_insn();
            bit [WORD_W-1:0]        word;
            bit [WORD_W-1:0]        opd;
            bit [WORD_W-1:0]        amt;
            bit [7:0]               opc;
            bit signed [WORD_W-1:0] fill;
            word = mem[t_addr'(pc)];
            opc  = word[7:0];
            opd  = {{8{word[WORD_W-1]}}, word[WORD_W-1:8]};
            amt  = reg_a;
            pc   = pc + 1;
            case (opc)
                OP_LDC: begin
                    reg_b = reg_a;
                    reg_a = opd;
                end
                OP_ADC: reg_a = reg_a + opd;
                OP_LDL: begin
                    reg_b = reg_a;
                    reg_a = mem[t_addr'(sp + opd)];
                end
                OP_STL: begin
                    mem[t_addr'(sp + opd)] = reg_a;
                    reg_a = reg_b;
                end
                OP_LDNL: reg_a = mem[t_addr'(reg_a + opd)];
                OP_STNL: mem[t_addr'(reg_a + opd)] = reg_b;
                OP_ADD: reg_a = reg_a + reg_b;
                OP_SUB: reg_a = reg_b - reg_a;
                OP_SHL: reg_a = (amt < 32) ? (reg_b << amt[4:0]) : '0;
                OP_SHR: begin
                    if (amt < 32) begin
                        fill = $signed(reg_b) >>> amt[4:0];
                    end else begin
                        fill = {WORD_W{reg_b[WORD_W-1]}};
                    end
                    reg_a = fill;
                end
                OP_ADJ: sp = sp + opd;
                OP_A2SP: begin
                    sp    = reg_a;
                    reg_a = reg_b;
                end
                OP_SP2A: begin
                    reg_b = reg_a;
                    reg_a = sp;
                end
                OP_CALL: begin
                    reg_b = reg_a;
                    reg_a = pc;
                    pc    = pc + opd;
                end
                OP_RET: begin
                    pc    = reg_a;
                    reg_a = reg_b;
                end
                OP_BRZ: if (reg_a == 0) pc = pc + opd;
                OP_BRLZ: if (reg_a[WORD_W-1]) pc = pc + opd;
                OP_BR: pc = pc + opd;
                OP_HALT: halted = 1'b1;
                default: ;
            endcase
        endfunction

        function void note_request(t_action act, logic [IN_ADDR_W-1:0] addr,
                                   logic [WORD_W-1:0] data);
            t_step_state want;
            want.rdata = '0;
            case (act)
                ACT_WRITE: mem[t_addr'(addr)] = data;
                ACT_EXEC: if (!halted && pc_in_program()) step_insn();
                ACT_READ: want.rdata = mem[t_addr'(addr)];
                default: ;
            endcase
            want.a  = reg_a;
            want.b  = reg_b;
            want.pc = pc;
            want.sp = sp;
            if (halted) begin
                want.status = RS_HALTED;
            end else if (!pc_in_program()) begin
                want.status = RS_PAST_END;
            end else begin
                want.status = RS_RUNNING;
            end
            expected_states.push_back(want);
        endfunction

        function void check_result(t_step_state got);
            t_step_state want;
            if (expected_states.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result with no request outstanding: a=%h pc=%h",
                             $time, got.a, got.pc);
                end
                return;
            end
            want = expected_states.pop_front();
            if (got.a !== want.a || got.b !== want.b || got.pc !== want.pc ||
                got.sp !== want.sp || got.status !== want.status ||
                got.rdata !== want.rdata) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: expected a=%h b=%h pc=%h sp=%h st=%0d rd=%h", $time,
                             want.a, want.b, want.pc, want.sp, want.status, want.rdata);
                    $display("%0t:   actual a=%h b=%h pc=%h sp=%h st=%0d rd=%h", $time,
                             got.a, got.b, got.pc, got.sp, got.status, got.rdata);
                end
            end
        endfunction
    endclass

endpackage

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Bench for the two-register stack processor step block: loads random
// programs, single-steps them with reads and writes mixed in, and checks the
// register state returned for every request against a tracker of its own.
// ----------------------------------------------------------------------------
module tb;

    import trsc_pkg::*;
    import stack_cpu_tb_pkg::*;

    localparam logic [7:0] OPC_TOP = 8'hFF;
    localparam t_opcode PLAIN_OPS [17] = '{
        OP_LDC, OP_ADC, OP_LDL, OP_STL, OP_LDNL, OP_STNL, OP_ADD, OP_SUB, OP_SHL,
        OP_SHR, OP_ADJ, OP_A2SP, OP_SP2A, OP_CALL, OP_BRZ, OP_BRLZ, OP_BR
    };

    logic                        clk         = 1'b0;
    logic                        rst_n       = 1'b0;
    logic                        req_valid   = 1'b0;
    logic                        req_stall;
    logic [ACTION_W-1:0]         req_action  = '0;
    logic [IN_ADDR_W-1:0]        req_address = '0;
    logic [WORD_W-1:0]           req_data    = '0;
    logic                        res_valid;
    logic                        res_stall   = 1'b0;
    logic signed [WORD_W-1:0]    res_a;
    logic signed [WORD_W-1:0]    res_b;
    logic signed [WORD_W-1:0]    res_pc;
    logic signed [WORD_W-1:0]    res_sp;
    logic [STATUS_W-1:0]         res_status;
    logic [WORD_W-1:0]           res_rdata;
    logic                        cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]            cfg_wr_data = '0;

    cpu_state_tracker tracker = new();
    logic [WORD_W-1:0] prog[$];
    bit  burst;
    int  items_sent;
    int  results_seen;
    int  hold_left;
    int  span_left;
    bit  held_once;

    two_register_stack_cpu_step dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (req_valid),
        .o_in_stall    (req_stall),
        .i_action      (req_action),
        .i_address     (req_address),
        .i_data_word   (req_data),
        .o_out_valid   (res_valid),
        .i_out_stall   (res_stall),
        .o_a_value     (res_a),
        .o_b_value     (res_b),
        .o_pc_value    (res_pc),
        .o_sp_value    (res_sp),
        .o_run_status  (res_status),
        .o_read_data   (res_rdata),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("tb: done, errors");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [WORD_W-1:0] insn(logic [7:0] opc, logic [23:0] opd);
        return {opd, opc};
    endfunction

    task automatic send_request(t_action act, logic [IN_ADDR_W-1:0] addr,
                                logic [WORD_W-1:0] data);
        int gap;
        gap = burst ? 0 : idle_len();
        repeat (gap) begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid   <= 1'b1;
        req_action  <= act;
        req_address <= addr;
        req_data    <= data;
        do @(posedge clk); while (req_stall);
        tracker.note_request(act, addr, data);
        items_sent++;
    endtask

    // drop the request line and let every outstanding result come back
    task automatic wait_idle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
    endtask

    task automatic write_length(logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        tracker.set_length(v);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_words(logic [IN_ADDR_W-1:0] base_addr);
        foreach (prog[i]) send_request(ACT_WRITE, base_addr + IN_ADDR_W'(i), prog[i]);
        prog.delete();
    endtask

    always @(posedge clk) begin : result_mon
        t_step_state got;
        if (rst_n && res_valid && !res_stall) begin
            got.a      = res_a;
            got.b      = res_b;
            got.pc     = res_pc;
            got.sp     = res_sp;
            got.status = t_status'(res_status);
            got.rdata  = res_rdata;
            tracker.check_result(got);
            results_seen++;
        end
    end

    // receiver pacing, with one long hold-off so the block backs up
    always @(negedge clk) begin : rx_pace
        int r;
        if (hold_left > 0) begin
            hold_left--;
            res_stall <= 1'b1;
        end else if (!held_once && results_seen >= 300) begin
            held_once = 1'b1;
            hold_left = 249;
            res_stall <= 1'b1;
        end else if (span_left > 0) begin
            span_left--;
        end else begin
            r = $urandom_range(0, 9);
            if (r < 3) begin
                res_stall <= 1'b1;
                span_left = idle_len();
            end else if (r == 9) begin
                res_stall <= 1'b0;
                span_left = $urandom_range(40, 150);
            end else begin
                res_stall <= 1'b0;
                span_left = idle_len();
            end
        end
    end

    initial begin : stimulus
        int                   r;
        int                   phase;
        int                   len_words;
        int                   n_exec;
        bit                   pc_far;
        t_opcode              op;
        logic [23:0]          opd;
        logic [WORD_W-1:0]    start;
        logic [IN_ADDR_W-1:0] base;
        logic [IN_ADDR_W-1:0] addr_now;
        logic [CFG_W-1:0]     new_len;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // field extremes, unused request, a step refused by an empty program
        write_length('0);
        send_request(ACT_READ, 16'h0000, 32'h0000_0000);
        send_request(ACT_READ, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(ACT_WRITE, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(ACT_READ, 16'hFFFF, 32'h0000_0000);
        send_request(ACT_NONE, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(ACT_EXEC, 16'h0000, 32'h0000_0000);

        // shifts out of range, skipped opcode, stack offsets that wrap
        prog = '{insn(OP_LDC, 24'h800000), insn(OP_LDC, 24'd40), insn(OP_SHR, 24'h0),
                 insn(OP_SHL, 24'h0), insn(OP_STL, 24'h7FFFFF), insn(OPC_TOP, 24'hFFFFFF),
                 insn(OP_LDL, 24'h7FFFFF)};
        new_len = CFG_W'(prog.size());
        load_words(16'h0000);
        wait_idle();
        write_length(new_len);
        repeat (8) send_request(ACT_EXEC, 16'($urandom), 32'($urandom));

        phase = 0;
        while (items_sent < 1820) begin
            wait_idle();
            phase++;
            burst = ($urandom_range(0, 5) == 0);
            start = tracker.pc;
            base  = start[IN_ADDR_W-1:0];
            pc_far = !start[WORD_W-1] && (start > WORD_W'(MEM_WORDS - 64));
            len_words = $urandom_range(6, 40);
            if (!pc_far) begin
                while (prog.size() < len_words) begin
                    addr_now = base + IN_ADDR_W'(prog.size());
                    r = $urandom_range(0, 99);
                    if (r < 4) begin
                        // jump into negative pc, fetch carries on at the next word
                        prog.push_back(insn(OP_BR, 24'h800000));
                    end else if (r < 8) begin
                        // come back to a positive pc at the word after the ret
                        prog.push_back(insn(OP_LDC, 24'(addr_now) + 24'd2));
                        prog.push_back(insn(OP_RET, 24'($urandom)));
                    end else if (r < 13) begin
                        prog.push_back(insn(OP_CALL, 24'd1));
                        prog.push_back(insn(OP_BR, 24'd1));
                        prog.push_back(insn(OP_RET, 24'($urandom)));
                    end else if (r < 21) begin
                        prog.push_back(insn(OP_LDC, 24'($urandom_range(0, 40))));
                        prog.push_back(insn(r[0] ? OP_SHL : OP_SHR, 24'($urandom)));
                    end else if (r < 28) begin
                        prog.push_back(insn(8'($urandom_range(OPCODE_COUNT, 255)),
                                            24'($urandom)));
                    end else begin
                        op = PLAIN_OPS[$urandom_range(0, 16)];
                        case (op)
                            OP_BRZ, OP_BRLZ, OP_BR: opd = 24'($urandom_range(0, 9)) - 24'd2;
                            OP_CALL: opd = 24'($urandom_range(0, 6));
                            OP_LDC, OP_ADC, OP_LDL, OP_LDNL: begin
                                if ($urandom_range(0, 1) == 0) begin
                                    opd = 24'($urandom_range(0, 40)) - 24'd20;
                                end else begin
                                    opd = 24'($urandom);
                                end
                            end
                            default: opd = 24'($urandom);
                        endcase
                        prog.push_back(insn(op, opd));
                    end
                end
                load_words(base);
                wait_idle();
            end

            r = $urandom_range(0, 9);
            if (start[WORD_W-1] || pc_far) begin
                new_len = CFG_W'($urandom_range(0, MEM_WORDS));
            end else if (phase == 3 || r == 0) begin
                new_len = CFG_W'(MEM_WORDS);
            end else if (r < 3) begin
                new_len = CFG_W'(start) + CFG_W'(len_words / 2);
            end else begin
                new_len = CFG_W'(start) + CFG_W'(len_words);
            end
            write_length(new_len);

            n_exec = $urandom_range(15, 70);
            repeat (n_exec) begin
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    send_request(ACT_READ, 16'($urandom), 32'($urandom));
                end else if (r < 10) begin
                    send_request(ACT_READ, base + 16'($urandom_range(0, 47)), 32'($urandom));
                end else if (r < 14) begin
                    // writes kept in the upper half, away from the code
                    send_request(ACT_WRITE, {1'b1, 15'($urandom)}, 32'($urandom));
                end else if (r < 16) begin
                    send_request(ACT_NONE, 16'($urandom), 32'($urandom));
                end else begin
                    send_request(ACT_EXEC, 16'($urandom), 32'($urandom));
                end
            end
        end

        // halt, then steps that must be refused
        wait_idle();
        burst = 1'b0;
        start = tracker.pc;
        base  = start[IN_ADDR_W-1:0];
        prog.push_back(insn(OP_HALT, 24'h7FFFFF));
        load_words(base);
        wait_idle();
        if (!start[WORD_W-1] && start < WORD_W'(MEM_WORDS)) begin
            write_length(CFG_W'(start) + CFG_W'(1));
        end else begin
            write_length(CFG_W'(MEM_WORDS));
        end
        repeat (3) send_request(ACT_EXEC, 16'($urandom), 32'($urandom));
        send_request(ACT_READ, base, 32'($urandom));

        wait_idle();
        repeat (20) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
